// ===== design/scalar_kalman_smoother_unit_defines.svh =====
// Assertion macros for the scalar Kalman smoother unit.
`ifndef SCALAR_KALMAN_SMOOTHER_UNIT_DEFINES_SVH
`define SCALAR_KALMAN_SMOOTHER_UNIT_DEFINES_SVH

// Check that cons holds in the same cycle as ante (clocked on i_clk, off in reset).
`define SKS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define SKS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/sks_pkg.sv =====
// Package of the scalar Kalman smoother: widths, register map, microcode ROM.
package sks_pkg;

    // Sample width and derived widths
    localparam int SAMPLE_BITS = 16;
    localparam int TGT_W       = SAMPLE_BITS + 16;
    localparam int MAG_W       = (TGT_W > 32) ? TGT_W : 32;

    // Gain fraction bits and divider counter
    localparam int K_FRAC   = 32;
    localparam int CNT_W    = $clog2(K_FRAC);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(K_FRAC - 1);

    localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;

    // Configuration register map
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MEASURE_NOISE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_ESTIMATE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_COVARIANCE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WARMUP_COUNT       = 3'd4;

    // Register reset values
    localparam logic [31:0] Q_RESET  = 32'd537;
    localparam logic [31:0] R_RESET  = 32'd53687091;
    localparam logic [31:0] E0_RESET = 32'd72089600;
    localparam logic [31:0] P0_RESET = 32'd1073741824;
    localparam logic [7:0]  W_RESET  = 8'd0;

    // Step addresses of the program
    localparam int PC_W = 4;
    typedef logic [PC_W-1:0] t_pc;
    localparam t_pc PC_IDLE  = 4'd0;
    localparam t_pc PC_CHECK = 4'd1;
    localparam t_pc PC_DEN   = 4'd2;
    localparam t_pc PC_DIV   = 4'd3;
    localparam t_pc PC_MUL1  = 4'd4;
    localparam t_pc PC_COV   = 4'd5;
    localparam t_pc PC_ACC   = 4'd6;
    localparam t_pc PC_EST   = 4'd7;
    localparam t_pc PC_EMIT  = 4'd8;

    // Datapath operations
    typedef logic [3:0] t_op;
    localparam t_op OP_NOP   = 4'd0;
    localparam t_op OP_IDLE  = 4'd1;
    localparam t_op OP_CHECK = 4'd2;
    localparam t_op OP_DEN   = 4'd3;
    localparam t_op OP_DIV   = 4'd4;
    localparam t_op OP_COV   = 4'd5;
    localparam t_op OP_ACC   = 4'd6;
    localparam t_op OP_EST   = 4'd7;
    localparam t_op OP_EMIT  = 4'd8;

    // Multiplier operand selection
    typedef logic [1:0] t_mul;
    localparam t_mul MUL_NONE = 2'd0;
    localparam t_mul MUL_COV  = 2'd1;
    localparam t_mul MUL_LO   = 2'd2;
    localparam t_mul MUL_HI   = 2'd3;

    // Sequencing conditions
    typedef logic [2:0] t_jmp;
    localparam t_jmp JMP_NEXT     = 3'd0;
    localparam t_jmp JMP_ALWAYS   = 3'd1;
    localparam t_jmp JMP_HOLD_IN  = 3'd2;
    localparam t_jmp JMP_WARM     = 3'd3;
    localparam t_jmp JMP_DENZ     = 3'd4;
    localparam t_jmp JMP_LOOP     = 3'd5;
    localparam t_jmp JMP_HOLD_OUT = 3'd6;

    typedef struct packed {
        t_op  op;
        t_mul mul;
        t_jmp jmp;
        t_pc  tgt;
    } t_uword;

    // Microcode ROM: one control word per step
    function automatic t_uword ucode(input t_pc pc);
        t_uword w;
        case (pc)
            PC_IDLE:  w = '{op: OP_IDLE,  mul: MUL_NONE, jmp: JMP_HOLD_IN,  tgt: PC_CHECK};
            PC_CHECK: w = '{op: OP_CHECK, mul: MUL_NONE, jmp: JMP_WARM,     tgt: PC_EMIT};
            PC_DEN:   w = '{op: OP_DEN,   mul: MUL_NONE, jmp: JMP_DENZ,     tgt: PC_MUL1};
            PC_DIV:   w = '{op: OP_DIV,   mul: MUL_NONE, jmp: JMP_LOOP,     tgt: PC_DIV};
            PC_MUL1:  w = '{op: OP_NOP,   mul: MUL_COV,  jmp: JMP_NEXT,     tgt: PC_IDLE};
            PC_COV:   w = '{op: OP_COV,   mul: MUL_LO,   jmp: JMP_NEXT,     tgt: PC_IDLE};
            PC_ACC:   w = '{op: OP_ACC,   mul: MUL_HI,   jmp: JMP_NEXT,     tgt: PC_IDLE};
            PC_EST:   w = '{op: OP_EST,   mul: MUL_NONE, jmp: JMP_NEXT,     tgt: PC_IDLE};
            PC_EMIT:  w = '{op: OP_EMIT,  mul: MUL_NONE, jmp: JMP_HOLD_OUT, tgt: PC_IDLE};
            default:  w = '{op: OP_NOP,   mul: MUL_NONE, jmp: JMP_ALWAYS,   tgt: PC_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ===== design/scalar_kalman_smoother_unit.sv =====
// Scalar Kalman smoother: microcoded sequencer over a divider and one 32x32 multiplier.
//
//   channel  direction  handshake                 payload
//   in       input      i_in_valid / o_in_stall   i_sample, i_restart
//   out      output     o_out_valid / i_out_stall o_estimate, o_warming
//   cfg      input      i_cfg_we                  i_cfg_index, i_cfg_data
//
// Filtered item, from accept to accept: warm-up check, divisor, 32 divider steps,
// three multiplier steps, estimate update, output load, idle step; a zero
// divisor skips the divider; a warm-up item goes from the check to the output load.
// Reset is synchronous and loads the register defaults and the initial state.
// A stalled output holds the sequencer at its last step; the next item is taken
// while a result waits.
`include "scalar_kalman_smoother_unit_defines.svh"

module scalar_kalman_smoother_unit
    import sks_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic                   i_restart,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [31:0]            o_estimate,
    output logic                   o_warming,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [31:0]            i_cfg_data
);

    // Configuration registers
    logic [31:0] r_q, r_r, r_e0, r_p0;
    logic [7:0]  r_warmup;

    // Filter state
    logic [31:0] r_est, n_est;
    logic [31:0] r_cov, n_cov;
    logic [7:0]  r_seen, n_seen;

    // Sequencer
    t_pc    r_pc, n_pc;
    t_uword uw;

    // Datapath registers
    logic [MAG_W-1:0] r_tgt, n_tgt;
    logic [MAG_W-1:0] r_mag, n_mag;
    logic [MAG_W-1:0] r_acc, n_acc;
    logic [31:0]      r_pp, n_pp;
    logic [32:0]      r_den, n_den;
    logic [32:0]      r_rem, n_rem;
    logic [31:0]      r_quo, n_quo;
    logic             r_kint, n_kint;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_warm, n_warm;
    logic [63:0]      r_prod;

    // Output register
    logic        r_ovalid;
    logic [31:0] r_oest;
    logic        r_owarm;

    // Combinational helpers
    logic             in_acc, out_acc, out_free;
    logic             warm_now, den_zero, k_zero, up;
    logic [32:0]      pp_sum, den_sum;
    logic [33:0]      rem2;
    logic             ge;
    logic [MAG_W-1:0] est_ext, step;
    logic [MAG_W:0]   up_sum;
    logic [31:0]      tgt_sat, mul_a, mul_b, mag_hi;
    logic [32:0]      one_minus_k;

    assign uw       = ucode(r_pc);
    assign in_acc   = i_in_valid && (uw.op == OP_IDLE);
    assign out_acc  = r_ovalid && !i_out_stall;
    assign out_free = !r_ovalid || !i_out_stall;

    assign o_in_stall  = (uw.op != OP_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_estimate  = r_oest;
    assign o_warming   = r_owarm;

    // Shared arithmetic terms
    assign warm_now    = (r_seen < r_warmup);
    assign pp_sum      = {1'b0, r_cov} + {1'b0, r_q};
    assign den_sum     = {1'b0, r_pp} + {1'b0, r_r};
    assign den_zero    = (den_sum == 33'd0);
    assign k_zero      = !r_kint && (r_quo == 32'd0);
    assign rem2        = {r_rem, 1'b0};
    assign ge          = (rem2 >= {1'b0, r_den});
    assign est_ext     = MAG_W'(r_est);
    assign up          = (r_tgt >= est_ext);
    assign tgt_sat     = (r_tgt > MAG_W'(MAX32)) ? MAX32 : r_tgt[31:0];
    assign step        = r_kint ? r_mag : (r_acc + MAG_W'(r_prod));
    assign up_sum      = {1'b0, est_ext} + {1'b0, step};
    assign one_minus_k = 33'h1_0000_0000 - {r_kint, r_quo};
    assign mag_hi      = 32'(r_mag >> 32);

    // Select multiplier operands
    always_comb begin
        case (uw.mul)
            MUL_COV: begin
                mul_a = one_minus_k[31:0];
                mul_b = r_pp;
            end
            MUL_LO: begin
                mul_a = r_mag[31:0];
                mul_b = r_quo;
            end
            MUL_HI: begin
                mul_a = mag_hi;
                mul_b = r_quo;
            end
            default: begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    // Sequence the program
    always_comb begin
        case (uw.jmp)
            JMP_NEXT:     n_pc = r_pc + 1'b1;
            JMP_ALWAYS:   n_pc = uw.tgt;
            JMP_HOLD_IN:  n_pc = in_acc ? uw.tgt : r_pc;
            JMP_WARM:     n_pc = warm_now ? uw.tgt : r_pc + 1'b1;
            JMP_DENZ:     n_pc = den_zero ? uw.tgt : r_pc + 1'b1;
            JMP_LOOP:     n_pc = (r_cnt != DIV_LAST) ? uw.tgt : r_pc + 1'b1;
            JMP_HOLD_OUT: n_pc = out_free ? uw.tgt : r_pc;
            default:      n_pc = PC_IDLE;
        endcase
    end

    // Execute the datapath operation of the current step
    always_comb begin
        n_est  = r_est;
        n_cov  = r_cov;
        n_seen = r_seen;
        n_tgt  = r_tgt;
        n_mag  = r_mag;
        n_acc  = r_acc;
        n_pp   = r_pp;
        n_den  = r_den;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_kint = r_kint;
        n_cnt  = r_cnt;
        n_warm = r_warm;
        case (uw.op)
            OP_IDLE: begin
                // take the sample, reload initial state on restart
                if (in_acc) begin
                    n_tgt = MAG_W'(i_sample) << 16;
                    if (i_restart) begin
                        n_est  = r_e0;
                        n_cov  = r_p0;
                        n_seen = 8'd0;
                    end
                end
            end
            OP_CHECK: begin
                if (warm_now) begin
                    // pass the sample through
                    n_est  = tgt_sat;
                    n_seen = r_seen + 8'd1;
                    n_warm = 1'b1;
                end else begin
                    // predict covariance, form the error magnitude
                    n_warm = 1'b0;
                    n_pp   = pp_sum[32] ? MAX32 : pp_sum[31:0];
                    n_mag  = up ? (r_tgt - est_ext) : (est_ext - r_tgt);
                end
            end
            OP_DEN: begin
                // seed the divider with the integer part of the gain
                n_den = den_sum;
                n_cnt = '0;
                n_quo = 32'd0;
                if (den_zero) begin
                    n_kint = 1'b0;
                    n_rem  = 33'd0;
                end else if ({1'b0, r_pp} >= den_sum) begin
                    n_kint = 1'b1;
                    n_rem  = {1'b0, r_pp} - den_sum;
                end else begin
                    n_kint = 1'b0;
                    n_rem  = {1'b0, r_pp};
                end
            end
            OP_DIV: begin
                // one restoring division step per cycle
                n_rem = ge ? 33'(rem2 - {1'b0, r_den}) : rem2[32:0];
                n_quo = {r_quo[30:0], ge};
                n_cnt = r_cnt + 1'b1;
            end
            OP_COV: begin
                n_cov = k_zero ? r_pp : r_prod[63:32];
            end
            OP_ACC: begin
                n_acc = MAG_W'(r_prod[63:32]);
            end
            OP_EST: begin
                // move the estimate toward the sample
                if (up) begin
                    n_est = (up_sum > (MAG_W+1)'(MAX32)) ? MAX32 : up_sum[31:0];
                end else begin
                    n_est = r_est - step[31:0];
                end
            end
            default: begin
            end
        endcase
    end

    // Configuration registers, filter state, sequencer and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q      <= Q_RESET;
            r_r      <= R_RESET;
            r_e0     <= E0_RESET;
            r_p0     <= P0_RESET;
            r_warmup <= W_RESET;
            r_est    <= E0_RESET;
            r_cov    <= P0_RESET;
            r_seen   <= 8'd0;
            r_pc     <= PC_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_PROCESS_NOISE:      r_q      <= i_cfg_data;
                    REG_MEASURE_NOISE:      r_r      <= i_cfg_data;
                    REG_INITIAL_ESTIMATE:   r_e0     <= i_cfg_data;
                    REG_INITIAL_COVARIANCE: r_p0     <= i_cfg_data;
                    REG_WARMUP_COUNT:       r_warmup <= i_cfg_data[7:0];
                    default: begin
                    end
                endcase
            end
            r_est  <= n_est;
            r_cov  <= n_cov;
            r_seen <= n_seen;
            r_pc   <= n_pc;
            // load the output register when free, drop it when taken
            if (uw.op == OP_EMIT && out_free) begin
                r_ovalid <= 1'b1;
            end else if (out_acc) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Datapath and output payload
    always_ff @(posedge i_clk) begin
        r_tgt  <= n_tgt;
        r_mag  <= n_mag;
        r_acc  <= n_acc;
        r_pp   <= n_pp;
        r_den  <= n_den;
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_kint <= n_kint;
        r_cnt  <= n_cnt;
        r_warm <= n_warm;
        if (uw.mul != MUL_NONE) begin
            r_prod <= 64'(mul_a) * 64'(mul_b);
        end
        if (uw.op == OP_EMIT && out_free) begin
            r_oest  <= r_est;
            r_owarm <= r_warm;
        end
    end

    // Sequencer checks
    `SKS_ASSERT_NEXT(a_accept_starts, in_acc, r_pc == PC_CHECK, "accepted item did not start")
    `SKS_ASSERT_SAME(a_div_full, (r_pc == PC_DIV) && (n_pc != PC_DIV), r_cnt == DIV_LAST,
        "divider left early")
    `SKS_ASSERT_SAME(a_gain_bound, r_pc == PC_MUL1, !r_kint || (r_quo == 32'd0),
        "gain above one")
    `SKS_ASSERT_NEXT(a_emit_holds, (r_pc == PC_EMIT) && !out_free,
        (r_pc == PC_EMIT) && r_ovalid, "result left while output stalled")

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the scalar Kalman smoother unit.
module testbench;
    import sks_pkg::*;

    localparam int          LIMIT_CYCLES = 500_000;
    localparam int          HOLD_AT      = 400;
    localparam int          LONG_HOLD    = 300;
    localparam logic [63:0] ONE_Q32      = 64'h1_0000_0000;
    localparam logic [63:0] WIDE_MAX32   = {32'd0, MAX32};

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample;
        logic                   restart;
    } t_item;

    typedef struct packed {
        logic [31:0] est;
        logic        warm;
    } t_result;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    t_item                cur_item  = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [31:0]          estimate;
    logic                 warming;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data  = '0;

    // Filter state and register copies
    logic [31:0] f_est, f_cov;
    logic [7:0]  f_seen;
    logic [31:0] c_q, c_r, c_e0, c_p0;
    logic [7:0]  c_warm;

    t_item   sample_queue[$];
    t_result est_due[$];
    int      fed_cnt    = 0;
    int      err_cnt    = 0;
    int      gap_left   = 0;
    int      stall_left = 0;
    int      hold_left  = 0;
    logic    hold_done  = 1'b0;
    logic    calm       = 1'b0;

    scalar_kalman_smoother_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_sample    (cur_item.sample),
        .i_restart   (cur_item.restart),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_estimate  (estimate),
        .o_warming   (warming),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    function automatic logic [31:0] clip32(input logic [63:0] v);
        return (v > WIDE_MAX32) ? MAX32 : v[31:0];
    endfunction

    // Advance the filter by one item and return the expected result
    function automatic t_result smooth_step(input t_item it);
        logic [63:0] tgt, pp, den, gain, mag, dstep;
        t_result     res;
        tgt = {{(64 - SAMPLE_BITS){1'b0}}, it.sample} << 16;
        if (it.restart) begin
            f_est  = c_e0;
            f_cov  = c_p0;
            f_seen = 8'd0;
        end
        if (f_seen < c_warm) begin
            f_est    = clip32(tgt);
            f_seen   = f_seen + 8'd1;
            res.est  = f_est;
            res.warm = 1'b1;
            return res;
        end
        pp = {32'd0, f_cov} + {32'd0, c_q};
        if (pp > WIDE_MAX32)
            pp = WIDE_MAX32;
        den  = pp + {32'd0, c_r};
        gain = (den == 64'd0) ? 64'd0 : (pp << 32) / den;
        if (gain > ONE_Q32)
            gain = ONE_Q32;
        f_cov = 32'(((ONE_Q32 - gain) * pp) >> 32);
        // Move toward the target, truncating toward the old estimate
        mag   = (tgt >= {32'd0, f_est}) ? tgt - {32'd0, f_est} : {32'd0, f_est} - tgt;
        dstep = (mag >> 32) * gain + (((mag & WIDE_MAX32) * gain) >> 32);
        if (tgt >= {32'd0, f_est})
            f_est = clip32({32'd0, f_est} + dstep);
        else
            f_est = 32'({32'd0, f_est} - dstep);
        res.est  = f_est;
        res.warm = 1'b0;
        return res;
    endfunction

    task automatic report_miss(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        err_cnt++;
        if (err_cnt <= 10)
            $display("mismatch on %s: expected %h, got %h", field, want, got);
    endtask

    // Driver: offer queued items, with random gaps
    always @(posedge clk) begin : feed
        if (!rst_n) begin
            in_valid <= 1'b0;
            gap_left <= 0;
        end else if (!in_valid || !in_stall) begin
            if (in_valid) begin
                est_due.push_back(smooth_step(cur_item));
                fed_cnt <= fed_cnt + 1;
            end
            if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end else if (sample_queue.size() != 0 && !calm && $urandom_range(0, 5) == 0) begin
                gap_left <= $urandom_range(0, 9);
                in_valid <= 1'b0;
            end else if (sample_queue.size() != 0) begin
                cur_item <= sample_queue.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off once enough items went in
    always @(posedge clk) begin : long_hold
        if (!rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && fed_cnt >= HOLD_AT) begin
            hold_left <= LONG_HOLD;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Monitor: check each result against the oldest expectation, drive output stalls
    always @(posedge clk) begin : out_check
        t_result want;
        logic    burst;
        if (!rst_n) begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end else begin
            if (out_valid && !out_stall) begin
                if (est_due.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("unexpected result: estimate %h warming %b", estimate, warming);
                end else begin
                    want = est_due.pop_front();
                    if (estimate !== want.est)
                        report_miss("estimate", want.est, estimate);
                    if (warming !== want.warm)
                        report_miss("warming", {31'd0, want.warm}, {31'd0, warming});
                end
            end
            burst = 1'b0;
            if (stall_left != 0) begin
                stall_left <= stall_left - 1;
                burst = 1'b1;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                stall_left <= $urandom_range(0, 9);
                burst = 1'b1;
            end
            out_stall <= burst || (hold_left != 0);
        end
    end

    // Write one register while the block is idle
    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_PROCESS_NOISE:      c_q    = val;
            REG_MEASURE_NOISE:      c_r    = val;
            REG_INITIAL_ESTIMATE:   c_e0   = val;
            REG_INITIAL_COVARIANCE: c_p0   = val;
            REG_WARMUP_COUNT:       c_warm = val[7:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (sample_queue.size() != 0 || in_valid || est_due.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic push_item(input logic [SAMPLE_BITS-1:0] s, input logic r);
        t_item it;
        it.sample  = s;
        it.restart = r;
        sample_queue.push_back(it);
    endtask

    function automatic logic [31:0] pick_noise();
        case ($urandom_range(0, 5))
            0:       return 32'd0;
            1:       return MAX32;
            2:       return 32'($urandom_range(1, 1023));
            3:       return 32'($urandom_range(0, 32'h00FF_FFFF));
            default: return 32'($urandom());
        endcase
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return SAMPLE_BITS'($urandom());
        endcase
    endfunction

    // Stimulus
    initial begin
        c_q    = Q_RESET;
        c_r    = R_RESET;
        c_e0   = E0_RESET;
        c_p0   = P0_RESET;
        c_warm = W_RESET;
        f_est  = E0_RESET;
        f_cov  = P0_RESET;
        f_seen = 8'd0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset defaults, field extremes and restart
        push_item('0, 1'b0);
        push_item('1, 1'b0);
        push_item(SAMPLE_BITS'(1), 1'b1);
        push_item(SAMPLE_BITS'(16'h8000), 1'b0);
        push_item('1, 1'b1);
        push_item('0, 1'b0);
        wait_drained();

        // Zero denominator: no noise and zero covariance
        set_reg(REG_PROCESS_NOISE, 32'd0);
        set_reg(REG_MEASURE_NOISE, 32'd0);
        set_reg(REG_INITIAL_ESTIMATE, 32'h1234_5678);
        set_reg(REG_INITIAL_COVARIANCE, 32'd0);
        @(negedge clk);
        push_item(SAMPLE_BITS'(1234), 1'b1);
        push_item(SAMPLE_BITS'(100), 1'b0);
        wait_drained();

        // Zero measurement noise: gain of one, then a zero denominator again
        set_reg(REG_INITIAL_COVARIANCE, 32'd1);
        @(negedge clk);
        push_item(SAMPLE_BITS'(500), 1'b1);
        push_item(SAMPLE_BITS'(7), 1'b0);
        wait_drained();

        // Register extremes, saturated covariance, short warm-up
        set_reg(REG_PROCESS_NOISE, MAX32);
        set_reg(REG_MEASURE_NOISE, MAX32);
        set_reg(REG_INITIAL_ESTIMATE, MAX32);
        set_reg(REG_INITIAL_COVARIANCE, MAX32);
        set_reg(REG_WARMUP_COUNT, 32'd2);
        @(negedge clk);
        push_item('1, 1'b1);
        push_item('0, 1'b0);
        push_item('0, 1'b0);
        push_item('1, 1'b0);
        push_item(SAMPLE_BITS'(123), 1'b0);
        wait_drained();

        // Unused indexes are ignored; longest warm-up
        for (int k = REG_WARMUP_COUNT + 1; k < (1 << CFG_IDX_W); k++)
            set_reg(CFG_IDX_W'(k), $urandom());
        set_reg(REG_WARMUP_COUNT, 32'd255);
        @(negedge clk);
        push_item('0, 1'b1);
        push_item('1, 1'b0);
        wait_drained();

        // Warm-up length changed without a restart
        set_reg(REG_WARMUP_COUNT, 32'd1);
        @(negedge clk);
        push_item(SAMPLE_BITS'(42), 1'b0);
        wait_drained();
        set_reg(REG_WARMUP_COUNT, 32'd4);
        @(negedge clk);
        push_item(SAMPLE_BITS'(9), 1'b0);
        push_item(SAMPLE_BITS'(10), 1'b0);
        push_item(SAMPLE_BITS'(11), 1'b0);
        wait_drained();

        // Random phases, each with its own settings
        for (int ph = 0; ph < 7; ph++) begin
            set_reg(REG_PROCESS_NOISE, pick_noise());
            set_reg(REG_MEASURE_NOISE, pick_noise());
            set_reg(REG_INITIAL_ESTIMATE, ($urandom_range(0, 3) == 0) ? MAX32 : $urandom());
            set_reg(REG_INITIAL_COVARIANCE, pick_noise());
            set_reg(REG_WARMUP_COUNT,
                    ($urandom_range(0, 9) == 0) ? 32'd255 : 32'($urandom_range(0, 4)));
            if ($urandom_range(0, 2) == 0)
                set_reg(CFG_IDX_W'($urandom_range(REG_WARMUP_COUNT + 1, (1 << CFG_IDX_W) - 1)),
                        $urandom());
            @(negedge clk);
            calm = (ph == 6);
            push_item(pick_sample(), $urandom_range(0, 1) == 1);
            for (int n = 1; n < 150; n++)
                push_item(pick_sample(), $urandom_range(0, 24) == 0);
            wait_drained();
        end

        // Let any stray result show up, then judge
        repeat (40) @(negedge clk);
        err_cnt += est_due.size();
        if (err_cnt == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Watchdog
    initial begin
        #(LIMIT_CYCLES * 20);
        $display("TB_ERROR");
        $finish;
    end

endmodule
